FILE: rtl/core/uart_transmitter_fifo_cts_rs485_assert.svh
// Assertion macros for the UART transmitter block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef UART_TRANSMITTER_FIFO_CTS_RS485_ASSERT_SVH
`define UART_TRANSMITTER_FIFO_CTS_RS485_ASSERT_SVH

// plain property
`define UTX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define UTX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/utx_pkg.sv
// Shared types, constants and helpers of the UART transmitter.
// No dependencies; used by every module of the block except utx_ram.
package utx_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int WORD_WIDTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = PTR_W;
  localparam int PERIOD_W   = 24;
  localparam int EN_CNT_W   = 25;
  localparam int BL_W       = 6;
  localparam int PADDR_W    = 5;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST  = 24'd1;
  localparam logic [PERIOD_W-1:0] STOP_PERIOD_RST = 24'd1;
  localparam logic [4:0]          DATA_BITS_RST   = 5'd8;

  // request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PUSH = 1'b1;

  // parity modes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  // register indexes
  typedef enum logic [2:0] {
    REG_BIT_PERIOD  = 3'd0,
    REG_STOP_PERIOD = 3'd1,
    REG_DATA_BITS   = 3'd2,
    REG_PARITY_MODE = 3'd3,
    REG_CTS_ENABLE  = 3'd4,
    REG_DRIVE_MODE  = 3'd5,
    REG_HOLD_TICKS  = 3'd6,
    REG_IRQ_THRESH  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [PERIOD_W-1:0] stop_period;
    logic [4:0]          data_bits;
    logic [1:0]          parity_mode;
    logic                cts_enable;
    logic                drive_enable_mode;
    logic [PERIOD_W-1:0] enable_hold_ticks;
    logic [3:0]          level_irq_threshold;
  } cfg_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_enable_line;
    logic       level_irq;
    logic       push_accepted;
    logic [3:0] fill_level;
    logic       frame_active;
  } res_t;

  // words waiting in the ring for a pair of indexes
  function automatic logic [FILL_W-1:0] fill_of(logic [PTR_W-1:0] wr, logic [PTR_W-1:0] rd);
    logic [PTR_W:0] diff;
    if (wr >= rd) begin
      diff = {1'b0, wr} - {1'b0, rd};
    end else begin
      diff = ({1'b0, wr} + (PTR_W+1)'(FIFO_DEPTH)) - {1'b0, rd};
    end
    return diff[FILL_W-1:0];
  endfunction

  // next ring index with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: rtl/core/utx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/utx_regs.sv
// APB configuration registers of the UART transmitter.
// Depends on utx_pkg for the register map and cfg_t.
module utx_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utx_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output utx_pkg::cfg_t               cfg_o
);

  utx_pkg::cfg_t     cfg_q;
  utx_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = utx_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period          <= utx_pkg::BIT_PERIOD_RST;
      cfg_q.stop_period         <= utx_pkg::STOP_PERIOD_RST;
      cfg_q.data_bits           <= utx_pkg::DATA_BITS_RST;
      cfg_q.parity_mode         <= utx_pkg::PAR_NONE;
      cfg_q.cts_enable          <= 1'b0;
      cfg_q.drive_enable_mode   <= 1'b0;
      cfg_q.enable_hold_ticks   <= '0;
      cfg_q.level_irq_threshold <= '0;
    end else if (wr_en) begin
      case (idx)
        utx_pkg::REG_BIT_PERIOD:  cfg_q.bit_period          <= pwdata[23:0];
        utx_pkg::REG_STOP_PERIOD: cfg_q.stop_period         <= pwdata[23:0];
        utx_pkg::REG_DATA_BITS:   cfg_q.data_bits           <= pwdata[4:0];
        utx_pkg::REG_PARITY_MODE: cfg_q.parity_mode         <= pwdata[1:0];
        utx_pkg::REG_CTS_ENABLE:  cfg_q.cts_enable          <= pwdata[0];
        utx_pkg::REG_DRIVE_MODE:  cfg_q.drive_enable_mode   <= pwdata[0];
        utx_pkg::REG_HOLD_TICKS:  cfg_q.enable_hold_ticks   <= pwdata[23:0];
        utx_pkg::REG_IRQ_THRESH:  cfg_q.level_irq_threshold <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (idx)
      utx_pkg::REG_BIT_PERIOD:  prdata = 32'(cfg_q.bit_period);
      utx_pkg::REG_STOP_PERIOD: prdata = 32'(cfg_q.stop_period);
      utx_pkg::REG_DATA_BITS:   prdata = 32'(cfg_q.data_bits);
      utx_pkg::REG_PARITY_MODE: prdata = 32'(cfg_q.parity_mode);
      utx_pkg::REG_CTS_ENABLE:  prdata = 32'(cfg_q.cts_enable);
      utx_pkg::REG_DRIVE_MODE:  prdata = 32'(cfg_q.drive_enable_mode);
      utx_pkg::REG_HOLD_TICKS:  prdata = 32'(cfg_q.enable_hold_ticks);
      utx_pkg::REG_IRQ_THRESH:  prdata = 32'(cfg_q.level_irq_threshold);
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/utx_core.sv
// Word ring and frame engine of the UART transmitter: one request per cycle while acc_i is high.
// Depends on utx_pkg, utx_ram and the assertion macro header.
`include "uart_transmitter_fifo_cts_rs485_assert.svh"

module utx_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  utx_pkg::cfg_t                  cfg_i,
  input  logic                           acc_i,
  input  logic                           req_type_i,
  input  logic [utx_pkg::WORD_WIDTH-1:0] push_word_i,
  input  logic                           cts_line_i,
  output utx_pkg::res_t                  res_o
);

  localparam int PW = utx_pkg::PTR_W;
  localparam int WW = utx_pkg::WORD_WIDTH;
  localparam int TW = utx_pkg::PERIOD_W;
  localparam int EW = utx_pkg::EN_CNT_W;
  localparam int BW = utx_pkg::BL_W;

  logic [PW-1:0]        rd_q, rd_d, wr_q, wr_d, wr_nxt, rd_nxt;
  logic [WW-1:0]        shift_q, shift_d;
  logic signed [BW-1:0] bl_q, bl_d;
  logic                 parity_q, parity_d;
  logic                 in_frame_q, in_frame_d;
  logic                 next_level_q, next_level_d;
  logic                 line_q, line_d;
  logic [TW-1:0]        tick_cnt_q, tick_cnt_d;
  logic                 en_active_q, en_active_d;
  logic [EW-1:0]        en_cnt_q, en_cnt_d;
  logic                 en_drop_q, en_drop_d;
  logic                 en_level_q, en_level_d;

  logic                 we;
  logic                 irq;
  logic                 push_ok;
  logic [WW-1:0]        ram_rdata;
  logic [WW-1:0]        head_w;
  logic                 fwd_valid_q;
  logic [WW-1:0]        fwd_data_q;
  logic [TW-1:0]        bit1, stop1;
  logic                 parity_on;

  assign bit1      = (cfg_i.bit_period == '0) ? TW'(1) : cfg_i.bit_period;
  assign stop1     = (cfg_i.stop_period == '0) ? TW'(1) : cfg_i.stop_period;
  assign parity_on = (cfg_i.parity_mode == utx_pkg::PAR_EVEN) ||
                     (cfg_i.parity_mode == utx_pkg::PAR_ODD);
  assign wr_nxt    = utx_pkg::ptr_inc(wr_q);
  assign rd_nxt    = utx_pkg::ptr_inc(rd_q);

  // word store: written at the write index, read ahead at the next read index
  utx_ram #(
    .WIDTH (WW),
    .DEPTH (utx_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_q),
    .wdata_i (push_word_i),
    .raddr_i (rd_d),
    .rdata_o (ram_rdata)
  );

  // forward a push into the entry being read ahead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= we && (wr_q == rd_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_word_i;
  end

  assign head_w = fwd_valid_q ? fwd_data_q : ram_rdata;

  // next state for one request
  always_comb begin
    rd_d         = rd_q;
    wr_d         = wr_q;
    shift_d      = shift_q;
    bl_d         = bl_q;
    parity_d     = parity_q;
    in_frame_d   = in_frame_q;
    next_level_d = next_level_q;
    line_d       = line_q;
    tick_cnt_d   = tick_cnt_q;
    en_active_d  = en_active_q;
    en_cnt_d     = en_cnt_q;
    en_drop_d    = en_drop_q;
    en_level_d   = en_level_q;
    we           = 1'b0;
    irq          = 1'b0;
    push_ok      = 1'b0;
    if (acc_i) begin
      if (req_type_i == utx_pkg::REQ_PUSH) begin
        if (wr_nxt != rd_q) begin
          we      = 1'b1;
          wr_d    = wr_nxt;
          push_ok = 1'b1;
        end
      end else begin
        // pending enable drop goes first
        if (en_drop_q) begin
          if (en_cnt_q <= EW'(1)) begin
            en_level_d = 1'b0;
            en_drop_d  = 1'b0;
            en_cnt_d   = '0;
          end else begin
            en_cnt_d = en_cnt_q - 1'b1;
          end
        end
        if (tick_cnt_q <= TW'(1)) begin
          line_d = next_level_q;
          if (in_frame_q) begin
            // schedule the next bit of the frame
            if (bl_q == '0) begin
              if (parity_on) begin
                next_level_d = parity_q;
              end else begin
                next_level_d = 1'b1;
                in_frame_d   = 1'b0;
              end
            end else if (bl_q < 0) begin
              next_level_d = 1'b1;
              in_frame_d   = 1'b0;
            end else begin
              next_level_d = shift_q[0];
              if (shift_q[0]) begin
                parity_d = ~parity_q;
              end
            end
            if (bl_q > -BW'(8)) begin
              bl_d = bl_q - BW'(1);
            end
            shift_d    = shift_q >> 1;
            tick_cnt_d = bit1;
          end else begin
            // idle check
            tick_cnt_d = stop1;
            if ((rd_q == wr_q) || (cfg_i.cts_enable && cts_line_i)) begin
              if (en_active_q) begin
                en_active_d = 1'b0;
                en_cnt_d    = EW'(stop1) + EW'(cfg_i.enable_hold_ticks);
                en_drop_d   = 1'b1;
              end
            end else begin
              if (cfg_i.drive_enable_mode) begin
                en_drop_d   = 1'b0;
                en_level_d  = 1'b1;
                en_active_d = 1'b1;
              end
              next_level_d = 1'b0;
              in_frame_d   = 1'b1;
              parity_d     = (cfg_i.parity_mode == utx_pkg::PAR_ODD);
              bl_d         = BW'(cfg_i.data_bits);
              shift_d      = head_w;
              rd_d         = rd_nxt;
              irq = (32'(utx_pkg::fill_of(wr_q, rd_nxt)) == 32'(cfg_i.level_irq_threshold));
            end
          end
        end else begin
          tick_cnt_d = tick_cnt_q - 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q         <= '0;
      wr_q         <= '0;
      shift_q      <= '0;
      bl_q         <= '0;
      parity_q     <= 1'b0;
      in_frame_q   <= 1'b0;
      next_level_q <= 1'b1;
      line_q       <= 1'b1;
      tick_cnt_q   <= utx_pkg::STOP_PERIOD_RST;
      en_active_q  <= 1'b0;
      en_cnt_q     <= '0;
      en_drop_q    <= 1'b0;
      en_level_q   <= 1'b0;
    end else begin
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      shift_q      <= shift_d;
      bl_q         <= bl_d;
      parity_q     <= parity_d;
      in_frame_q   <= in_frame_d;
      next_level_q <= next_level_d;
      line_q       <= line_d;
      tick_cnt_q   <= tick_cnt_d;
      en_active_q  <= en_active_d;
      en_cnt_q     <= en_cnt_d;
      en_drop_q    <= en_drop_d;
      en_level_q   <= en_level_d;
    end
  end

  // result of this request
  always_comb begin
    res_o.tx_line        = line_d;
    res_o.tx_enable_line = en_level_d;
    res_o.level_irq      = irq;
    res_o.push_accepted  = push_ok;
    res_o.fill_level     = 4'(utx_pkg::fill_of(wr_d, rd_d));
    res_o.frame_active   = in_frame_d;
  end

  `UTX_ASSERT_IMPL(a_push_only_on_push, res_o.push_accepted, acc_i && req_type_i, "push stored without a push request")
  `UTX_ASSERT_IMPL(a_irq_at_frame_start, res_o.level_irq, in_frame_d && !in_frame_q, "level interrupt without a pop")
  `UTX_ASSERT_IMPL(a_frame_needs_pop, $rose(in_frame_q), rd_q != $past(rd_q), "frame started without moving the read index")
  `UTX_ASSERT_NEXT(a_head_forward, we && (wr_q == rd_d), head_w == $past(push_word_i), "head word lost a forwarded push")

endmodule

FILE: rtl/core/uart_transmitter_fifo_cts_rs485.sv
// UART transmitter with word FIFO, clear-to-send hold-off and RS-485 enable.
// Requests enter on the input channel (in_valid_i / in_stall_o): req_type_i 0 is one
// timer tick, 1 pushes push_word_i into the 16-entry ring (15 words usable).
// Each request yields exactly one result on the output channel (out_valid_o /
// out_stall_i): line level, RS-485 enable level, level interrupt, push status,
// fill level and frame flag as they stand after that request.
// The result is registered in the output queue and offered after earlier results.
// Throughput: one request per clock while in_stall_o is low; the ring is one RAM that
// is read ahead at the next read index every cycle, with a push into that entry forwarded.
// A two-entry output queue lets requests flow while one result waits; in_stall_o
// rises only when both entries are full, so a stalling receiver backs up the
// input after two results.
// Reset (rst_ni low, asynchronous) empties the ring, sets the line high, the enable low
// and loads the default registers. The user must write registers over the APB port
// (byte address 4*index) only while no request is in flight; this is not enforced.
// Depends on utx_pkg, utx_regs, utx_core and utx_ram.
module uart_transmitter_fifo_cts_rs485 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [utx_pkg::WORD_WIDTH-1:0] push_word_i,
  input  logic                           cts_line_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           tx_line_o,
  output logic                           tx_enable_line_o,
  output logic                           level_irq_o,
  output logic                           push_accepted_o,
  output logic [3:0]                     fill_level_o,
  output logic                           frame_active_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [utx_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  utx_pkg::cfg_t cfg;
  utx_pkg::res_t res;
  utx_pkg::res_t slot0_q, slot1_q;
  logic [1:0]    cnt_q;
  logic          in_acc, out_acc;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;

  utx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  utx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .acc_i       (in_acc),
    .req_type_i  (req_type_i),
    .push_word_i (push_word_i),
    .cts_line_i  (cts_line_i),
    .res_o       (res)
  );

  // output queue occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // output queue payload, slot0 is the head
  always_ff @(posedge clk_i) begin
    if (in_acc && !out_acc) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= res;
      end else begin
        slot1_q <= res;
      end
    end else if (out_acc && !in_acc) begin
      slot0_q <= slot1_q;
    end else if (in_acc && out_acc) begin
      if (cnt_q == 2'd1) begin
        slot0_q <= res;
      end else begin
        slot0_q <= slot1_q;
        slot1_q <= res;
      end
    end
  end

  assign tx_line_o        = slot0_q.tx_line;
  assign tx_enable_line_o = slot0_q.tx_enable_line;
  assign level_irq_o      = slot0_q.level_irq;
  assign push_accepted_o  = slot0_q.push_accepted;
  assign fill_level_o     = slot0_q.fill_level;
  assign frame_active_o   = slot0_q.frame_active;

endmodule
